@@ hw/rtl/lcdw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared constants and types for the serial line to character LCD writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int BUFFER_CHARS_DEF = 32;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_ROW2     = 8'hC0;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

endpackage

@@ hw/rtl/lcdw_ram.sv @@
// ----------------------------------------------------------------------------
// lcdw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lcdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/lcdw_flush_seq.sv @@
// ----------------------------------------------------------------------------
// lcdw_flush_seq
// Walks the line store and emits the display write sequence of one flush.
// ----------------------------------------------------------------------------
module lcdw_flush_seq #(
  parameter int BUFFER_CHARS = lcdw_pkg::BUFFER_CHARS_DEF,
  parameter int CW = $clog2(BUFFER_CHARS + 1),
  parameter int AW = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [CW-1:0]         n_chars,
  input  logic [CW-1:0]         fill_count,
  input  logic [7:0]            rd_data,
  output logic [AW-1:0]         rd_addr,
  output lcdw_pkg::seq_status_t status,
  output logic                  strobe,
  output logic                  register_select,
  output logic [7:0]            lcd_byte,
  output logic                  last
);

  import lcdw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_CHAR = 2'd2;
  localparam logic [1:0] S_ROW  = 2'd3;

  logic [1:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] idx_inc;
  logic [5:0]    idx6;
  logic          is_last_char;
  logic          row_break;
  logic          emit;
  logic          emit_rs;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          done;

  assign idx_inc      = idx + CW'(1);
  assign idx6         = 6'(idx);
  assign is_last_char = (idx_inc == n_chars);
  assign row_break    = (idx6[3:0] == 4'hF);
  assign rd_addr      = (state == S_HEAD) ? '0 : idx_inc[AW-1:0];

  always_comb begin
    state_next = state;
    idx_next   = idx;
    emit       = 1'b0;
    emit_rs    = 1'b0;
    emit_byte  = CMD_SET_ADDR;
    emit_last  = 1'b0;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        emit      = 1'b1;
        emit_last = (n_chars == '0);
        idx_next  = '0;
        if (n_chars == '0) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        emit      = 1'b1;
        emit_rs   = 1'b1;
        emit_byte = (idx < fill_count) ? rd_data : CHAR_SPACE;
        emit_last = is_last_char && !row_break;
        if (row_break) begin
          state_next = S_ROW;
        end else if (is_last_char) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_ROW: begin
        emit      = 1'b1;
        emit_byte = idx6[4] ? CMD_SET_ADDR : CMD_ROW2;
        emit_last = is_last_char;
        if (is_last_char) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_CHAR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
    idx             <= idx_next;
    register_select <= emit_rs;
    lcd_byte        <= emit_byte;
    last            <= emit_last;
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = done;

endmodule

@@ hw/rtl/serial_line_to_char_lcd_writer_core.sv @@
// ----------------------------------------------------------------------------
// serial_line_to_char_lcd_writer_core
// Collects received bytes into a line store and flushes it to a 16x2 LCD.
// ----------------------------------------------------------------------------
// Input: an item (rx_byte) is taken at a clock edge with start high and busy
// low. Bytes 32..255 are appended to the line store while there is room;
// a full store drops them. Carriage return starts a flush; other bytes are
// ignored. An appended or ignored byte never raises busy.
// Flush: busy is high while the address command, the n characters walked and
// the r row commands (at most 2) are formed, one result per cycle, set by the
// single read port of the line store RAM. Results are registered and appear
// in the cycle after they are formed, each on register_select / lcd_byte /
// last for one cycle with strobe high; last marks the final item. The next
// input may be taken while that final item is on the ports. The receiver
// cannot stall the block. Reset: fill count and flushed flag clear; the RAM
// needs no clearing pass, since unwritten entries are not walked before the
// first flush and are sent as spaces after it.
// ----------------------------------------------------------------------------
module serial_line_to_char_lcd_writer_core #(
  parameter int BUFFER_CHARS = lcdw_pkg::BUFFER_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] rx_byte,
  output logic       strobe,
  output logic       register_select,
  output logic [7:0] lcd_byte,
  output logic       last
);

  import lcdw_pkg::*;

  localparam int CW = $clog2(BUFFER_CHARS + 1);
  localparam int AW = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;

  logic [CW-1:0] fill_count, fill_count_next;
  logic          flushed, flushed_next;
  logic [CW-1:0] n_chars;
  logic          accept;
  logic          wr_en;
  logic          go;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  seq_status_t   status;

  assign busy    = status.busy;
  assign accept  = start && !status.busy;
  assign go      = accept && (rx_byte == CHAR_CR);
  assign wr_en   = accept && (rx_byte >= CHAR_SPACE) && (fill_count < CW'(BUFFER_CHARS));
  assign n_chars = flushed ? CW'(BUFFER_CHARS) : fill_count;

  always_comb begin
    fill_count_next = fill_count;
    flushed_next    = flushed;
    if (status.done) begin
      fill_count_next = '0;
      flushed_next    = 1'b1;
    end else if (wr_en) begin
      fill_count_next = fill_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      flushed    <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      flushed    <= flushed_next;
    end
  end

  lcdw_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_CHARS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lcdw_flush_seq #(
    .BUFFER_CHARS (BUFFER_CHARS),
    .CW           (CW),
    .AW           (AW)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .n_chars         (n_chars),
    .fill_count      (fill_count),
    .rd_data         (rd_data),
    .rd_addr         (rd_addr),
    .status          (status),
    .strobe          (strobe),
    .register_select (register_select),
    .lcd_byte        (lcd_byte),
    .last            (last)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(BUFFER_CHARS))
    else $error("fill count beyond store depth");

  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && last))
    else $error("flush ended without final item");

  a_idle_strobe: assert property (@(posedge clk) disable iff (rst)
    (strobe && !busy) |-> last)
    else $error("item emitted while idle is not the final one");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(fill_count) || (fill_count == '0))
    else $error("fill count moved during flush");

endmodule

@@ test/serial_line_to_char_lcd_writer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_to_char_lcd_writer_core_tb
// Feeds received bytes through the start/busy handshake and checks every
// display write against a line store model kept beside the block. Directed
// bytes cover the flush right after reset, control bytes and the field
// extremes. Random lines of bytes 32..255 follow, some long enough to fill
// the store, mixed with stray control bytes, lines left open and idle gaps
// on the input side.
// ----------------------------------------------------------------------------
module serial_line_to_char_lcd_writer_core_tb;
  import lcdw_pkg::*;

  localparam int LINE_CHARS  = BUFFER_CHARS_DEF;
  localparam int ROW_CHARS   = 16;
  localparam int LINE_ITEMS  = 270;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 2000;

  class lcd_flush_tracker;
    typedef struct packed {
      logic       rs;
      logic [7:0] data;
      logic       last;
    } lcd_write_t;

    logic [7:0]  line_chars [LINE_CHARS];
    int unsigned fill;
    lcd_write_t  pending_writes [$];
    lcd_write_t  held;
    bit          have_held;
    int          errors;

    function new();
      foreach (line_chars[i]) line_chars[i] = 8'h00;
      fill = 0;
      errors = 0;
      have_held = 0;
    endfunction

    function void add_write(logic rs, logic [7:0] data);
      if (have_held) pending_writes.push_back(held);
      held = '{rs: rs, data: data, last: 1'b0};
      have_held = 1;
    endfunction

    function void take_byte(logic [7:0] b);
      int n;
      if (b == CHAR_CR) begin
        have_held = 0;
        n = 0;
        while (n < LINE_CHARS && line_chars[n] != 8'h00) n++;
        add_write(1'b0, CMD_SET_ADDR);
        for (int i = 0; i < n; i++) begin
          add_write(1'b1, line_chars[i]);
          if (i == ROW_CHARS - 1) add_write(1'b0, CMD_ROW2);
          else if (i == 2 * ROW_CHARS - 1) add_write(1'b0, CMD_SET_ADDR);
        end
        held.last = 1'b1;
        pending_writes.push_back(held);
        have_held = 0;
        foreach (line_chars[i]) line_chars[i] = CHAR_SPACE;
        fill = 0;
      end else if (b >= CHAR_SPACE && fill < LINE_CHARS) begin
        line_chars[fill] = b;
        fill++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_write(logic rs, logic [7:0] data, logic is_last);
      lcd_write_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected write rs=%0b byte=%02h last=%0b", rs, data, is_last));
        return;
      end
      want = pending_writes.pop_front();
      if (rs !== want.rs)
        report($sformatf("register_select %0b, want %0b", rs, want.rs));
      if (data !== want.data)
        report($sformatf("lcd_byte %02h, want %02h", data, want.data));
      if (is_last !== want.last)
        report($sformatf("last %0b, want %0b (byte %02h)", is_last, want.last, want.data));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] rx_byte;
  logic       strobe;
  logic       register_select;
  logic [7:0] lcd_byte;
  logic       last;

  lcd_flush_tracker sb = new();
  int unsigned      cycles;
  int               counted;

  serial_line_to_char_lcd_writer_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .rx_byte         (rx_byte),
    .strobe          (strobe),
    .register_select (register_select),
    .lcd_byte        (lcd_byte),
    .last            (last)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_write(register_select, lcd_byte, last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task send_item(logic [7:0] b);
    start   <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (busy);
    sb.take_byte(b);
  endtask

  task idle_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 88) n = $urandom_range(1, 3);
    else if (pick < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start   <= 1'b0;
      rx_byte <= 8'($urandom_range(0, 255));
      repeat (n) @(posedge clk);
    end
  endtask

  task wait_drained();
    if (sb.pending() != 0) begin
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end
  endtask

  initial begin
    logic [7:0] directed [$];
    logic [7:0] b;
    int         len;
    int         pick;
    bit         burst;
    int         waited;

    directed = '{8'd0, CHAR_CR, 8'd31, CHAR_SPACE, 8'd255, 8'd127, 8'd128, 8'd1,
                 8'h55, 8'hAA, 8'd10, 8'd9, 8'h7E, CHAR_CR, CHAR_CR};
    cycles  = 0;
    counted = 0;
    rst     = 1'b1;
    start   = 1'b0;
    rx_byte = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      idle_gap();
      send_item(directed[i]);
    end
    wait_drained();

    while (counted < LINE_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 31);
      else if (pick < 9) len = $urandom_range(32, 40);
      else len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 31));
        else b = 8'($urandom_range(32, 255));
        if (!burst) idle_gap();
        send_item(b);
        counted++;
      end
      if ($urandom_range(0, 7) != 0) begin
        if (!burst) idle_gap();
        send_item(CHAR_CR);
        counted++;
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    start  <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d writes never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
